[hdl/three_voice_wavetable_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the three-voice wavetable sequencer
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREE_VOICE_WAVETABLE_SEQUENCER_ASSERT_SVH
`define THREE_VOICE_WAVETABLE_SEQUENCER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define TVWS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define TVWS_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

[hdl/tvws_pkg.sv]
// ----------------------------------------------------------------------------
// tvws_pkg
// Types, codes and constants of the three-voice wavetable sequencer.
// ----------------------------------------------------------------------------
package tvws_pkg;

    localparam int NUM_VOICES = 3;

    typedef logic [15:0] t_word;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_SINE = 2'd1,
        ACT_SONG = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_TRIPLE = 2'd2
    } t_track_mode;

    typedef enum logic [2:0] {
        CFG_TRACK_MODE  = 3'd0,
        CFG_SONG_LENGTH = 3'd1,
        CFG_NOTE_TICKS  = 3'd2,
        CFG_TICKS_PER_S = 3'd3
    } t_cfg_index;

    localparam t_word      PHASE_LIMIT      = 16'h803F;
    localparam t_word      NOTE_TICKS_RESET = 16'h07A1;
    localparam t_word      TPS_RESET        = 16'hF424;
    localparam logic [8:0] SONG_LEN_RESET   = 9'd1;

    // add increment minus one, wrap, and restart past the limit
    function automatic t_word f_advance_phase(input t_word phase, input t_word inc);
        t_word sum;
        sum = phase + inc + 16'hFFFF;
        return (sum > PHASE_LIMIT) ? 16'h0000 : sum;
    endfunction

endpackage

[hdl/three_voice_wavetable_sequencer.sv]
// ----------------------------------------------------------------------------
// three_voice_wavetable_sequencer
// Sample-tick tone generator: three phase accumulators read a sine store,
// note increments come from a song store, and a seconds clock counts ticks.
// ----------------------------------------------------------------------------
// One request is taken every cycle while o_stall is low; a tick's sample passes
// the input register, the sine RAM read and the output register before it leaves.
// The song entry for the current note is fetched ahead from its RAM, and each
// voice reads its own copy of the sine store, so three lookups fit one cycle.
// Both stores come up unwritten and are never cleared: load every sine entry
// and song note in use before ticking. Writes take effect for the next tick.
`include "three_voice_wavetable_sequencer_assert.svh"

module three_voice_wavetable_sequencer #(
    parameter int SINE_DEPTH = 1024,
    parameter int SONG_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [9:0]  i_entry_address,
    input  logic [15:0] i_first_word,
    input  logic [15:0] i_second_word,
    input  logic [15:0] i_third_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pin_word,
    output logic [31:0] o_seconds_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    import tvws_pkg::*;

    localparam int SINE_AW = (SINE_DEPTH > 1) ? $clog2(SINE_DEPTH) : 1;
    localparam int SONG_AW = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;
    localparam int SONG_W  = 16 * NUM_VOICES;

    logic [1:0]  r_track_mode;
    logic [8:0]  r_song_length;
    t_word       r_note_ticks;
    t_word       r_ticks_per_s;

    logic        r_in_valid;
    logic [1:0]  r_in_action;
    logic [9:0]  r_in_addr;
    t_word       r_in_word [NUM_VOICES];

    t_word       r_phase [NUM_VOICES];
    t_word       n_phase [NUM_VOICES];
    logic [7:0]  r_note_index;
    logic [7:0]  n_note_index;
    t_word       r_note_count;
    t_word       n_note_count;
    logic [1:0]  r_prev_track;
    logic [1:0]  n_prev_track;
    t_word       r_sub_ticks;
    t_word       n_sub_ticks;
    logic [31:0] r_second_total;
    logic [31:0] n_second_total;

    logic              r_song_fwd;
    logic              n_song_fwd;
    logic [SONG_W-1:0] r_song_fwd_data;
    logic              r_song_oor;
    logic              n_song_oor;
    logic [SONG_W-1:0] song_q;
    logic [SONG_W-1:0] song_wr_data;
    logic [SONG_W-1:0] song_word;
    logic              song_wr_en;
    logic [7:0]        song_rd_idx;
    logic [9:0]        song_rd_ext;

    logic              sine_wr_en;
    logic [SINE_AW-1:0] sine_rd_addr [NUM_VOICES];
    t_word             sine_q       [NUM_VOICES];
    logic [NUM_VOICES-1:0] n_sine_oor;

    logic                  r_mid_valid;
    logic [1:0]            r_mid_mode;
    logic [NUM_VOICES-1:0] r_mid_oor;
    logic [31:0]           r_mid_seconds;
    t_word                 sample [NUM_VOICES];
    t_word                 mix;

    logic        r_out_valid;
    t_word       r_out_pin;
    logic [31:0] r_out_seconds;

    logic        advance;
    logic        tick;
    logic        track_chg;
    t_word       phase_base [NUM_VOICES];
    t_word       inc        [NUM_VOICES];
    logic [7:0]  idx_base;
    t_word       cnt_base;
    logic [8:0]  idx_next;
    t_word       sub_inc;

    assign advance     = !r_out_valid || !i_stall;
    assign o_stall     = !advance;
    assign o_cfg_ready = 1'b1;
    assign tick        = r_in_valid && (r_in_action == ACT_TICK);
    assign track_chg   = (r_prev_track != r_track_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_mode  <= MODE_SINGLE;
            r_song_length <= SONG_LEN_RESET;
            r_note_ticks  <= NOTE_TICKS_RESET;
            r_ticks_per_s <= TPS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRACK_MODE:  r_track_mode  <= i_cfg_data[1:0];
                CFG_SONG_LENGTH: r_song_length <= i_cfg_data[8:0];
                CFG_NOTE_TICKS:  r_note_ticks  <= i_cfg_data;
                CFG_TICKS_PER_S: r_ticks_per_s <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_in_action  <= i_action;
            r_in_addr    <= i_entry_address;
            r_in_word[0] <= i_first_word;
            r_in_word[1] <= i_second_word;
            r_in_word[2] <= i_third_word;
        end
    end

    assign song_word = r_song_fwd ? r_song_fwd_data : song_q;

    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            phase_base[v] = track_chg ? 16'h0000 : r_phase[v];
            inc[v]        = r_song_oor ? 16'h0000 : song_word[16*v +: 16];
            n_phase[v]    = r_phase[v];
        end
        idx_base       = track_chg ? 8'd0 : r_note_index;
        cnt_base       = track_chg ? 16'h0000 : r_note_count;
        idx_next       = {1'b0, idx_base} + 9'd1;
        sub_inc        = r_sub_ticks + 16'd1;
        n_note_index   = r_note_index;
        n_note_count   = r_note_count;
        n_prev_track   = r_prev_track;
        n_sub_ticks    = r_sub_ticks;
        n_second_total = r_second_total;
        if (tick) begin
            n_prev_track = r_track_mode;
            n_note_index = idx_base;
            n_note_count = cnt_base;
            for (int v = 0; v < NUM_VOICES; v++) begin
                n_phase[v] = phase_base[v];
            end
            if (r_track_mode == MODE_SINGLE || r_track_mode == MODE_TRIPLE) begin
                n_phase[0] = f_advance_phase(phase_base[0], inc[0]);
                if (r_track_mode == MODE_TRIPLE) begin
                    n_phase[1] = f_advance_phase(phase_base[1], inc[1]);
                    n_phase[2] = f_advance_phase(phase_base[2], inc[2]);
                end
                if (cnt_base < r_note_ticks) begin
                    n_note_count = cnt_base + 16'd1;
                end else begin
                    n_note_count = 16'h0000;
                    n_note_index = (idx_next >= r_song_length || idx_next[8])
                                   ? 8'd0 : idx_next[7:0];
                end
            end
            if (sub_inc >= r_ticks_per_s) begin
                n_sub_ticks    = 16'h0000;
                n_second_total = r_second_total + 32'd1;
            end else begin
                n_sub_ticks = sub_inc;
            end
        end
    end

    // fetch the song entry of the note the next tick will play; form store writes and sine read addresses
    always_comb begin
        song_rd_idx  = (r_track_mode != n_prev_track) ? 8'd0 : n_note_index;
        song_rd_ext  = {2'b00, song_rd_idx};
        n_song_oor   = !({1'b0, song_rd_ext} < 11'(SONG_DEPTH));
        song_wr_en   = advance && r_in_valid && (r_in_action == ACT_SONG)
                       && ({1'b0, r_in_addr} < 11'(SONG_DEPTH));
        song_wr_data = {r_in_word[2], r_in_word[1], r_in_word[0]};
        n_song_fwd   = song_wr_en && (r_in_addr == song_rd_ext);
        sine_wr_en   = advance && r_in_valid && (r_in_action == ACT_SINE)
                       && ({1'b0, r_in_addr} < 11'(SINE_DEPTH));
        for (int v = 0; v < NUM_VOICES; v++) begin
            sine_rd_addr[v] = n_phase[v][6 +: SINE_AW];
            n_sine_oor[v]   = !({1'b0, n_phase[v][15:6]} < 11'(SINE_DEPTH));
        end
    end

    tvws_ram #(
        .WIDTH (SONG_W),
        .DEPTH (SONG_DEPTH)
    ) u_song_ram (
        .i_clk     (i_clk),
        .i_wr_en   (song_wr_en),
        .i_wr_addr (r_in_addr[SONG_AW-1:0]),
        .i_wr_data (song_wr_data),
        .i_rd_en   (advance),
        .i_rd_addr (song_rd_ext[SONG_AW-1:0]),
        .o_rd_data (song_q)
    );

    for (genvar g = 0; g < NUM_VOICES; g++) begin : g_sine
        tvws_ram #(
            .WIDTH (16),
            .DEPTH (SINE_DEPTH)
        ) u_sine_ram (
            .i_clk     (i_clk),
            .i_wr_en   (sine_wr_en),
            .i_wr_addr (r_in_addr[SINE_AW-1:0]),
            .i_wr_data (r_in_word[0]),
            .i_rd_en   (advance),
            .i_rd_addr (sine_rd_addr[g]),
            .o_rd_data (sine_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_phase[v] <= 16'h0000;
            end
            r_note_index   <= 8'd0;
            r_note_count   <= 16'h0000;
            r_prev_track   <= MODE_SINGLE;
            r_sub_ticks    <= 16'h0000;
            r_second_total <= 32'd0;
            r_song_fwd     <= 1'b0;
            r_mid_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else if (advance) begin
            r_phase        <= n_phase;
            r_note_index   <= n_note_index;
            r_note_count   <= n_note_count;
            r_prev_track   <= n_prev_track;
            r_sub_ticks    <= n_sub_ticks;
            r_second_total <= n_second_total;
            r_song_fwd     <= n_song_fwd;
            r_mid_valid    <= tick;
            r_out_valid    <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_song_fwd_data <= song_wr_data;
            r_song_oor      <= n_song_oor;
            r_mid_mode      <= r_track_mode;
            r_mid_oor       <= n_sine_oor;
            r_mid_seconds   <= n_second_total;
            r_out_pin       <= mix;
            r_out_seconds   <= r_mid_seconds;
        end
    end

    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            sample[v] = r_mid_oor[v] ? 16'h0000 : sine_q[v];
        end
        case (r_mid_mode)
            MODE_SINGLE: mix = {sample[0][9:0], 6'b0};
            MODE_TRIPLE: mix = {sample[0][9:0], 6'b0} + {sample[1][10:0], 5'b0}
                               + {sample[2][11:0], 4'b0};
            default:     mix = 16'h0000;
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_pin_word      = r_out_pin;
    assign o_seconds_count = r_out_seconds;

    `TVWS_ASSERT(a_phase_in_range, (r_phase[0] <= PHASE_LIMIT) && (r_phase[1] <= PHASE_LIMIT) && (r_phase[2] <= PHASE_LIMIT), "phase above restart limit")
    `TVWS_ASSERT(a_silent_output, (advance && r_mid_valid && r_mid_mode != MODE_SINGLE && r_mid_mode != MODE_TRIPLE) |=> (r_out_pin == 16'h0000), "silent mode produced a nonzero sample")
    `TVWS_ASSERT(a_single_holds_voice2, (advance && tick && r_track_mode == MODE_SINGLE && r_prev_track == MODE_SINGLE) |=> $stable(r_phase[1]), "voice two moved in single-voice mode")
    `TVWS_ASSERT_NEVER(a_write_no_result, advance && r_in_valid && r_in_action != ACT_TICK && tick, "store write treated as a tick")
    `TVWS_ASSERT(a_write_no_second, (advance && !tick) |=> $stable(r_second_total), "seconds moved without a tick")

endmodule

[hdl/tvws_ram.sv]
// ----------------------------------------------------------------------------
// tvws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tvws_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
